[hw/rtl/convex_polygon_sat_overlap_top_assert.svh]
// Assertion macros for the polygon overlap block.
`ifndef CONVEX_POLYGON_SAT_OVERLAP_TOP_ASSERT_SVH
`define CONVEX_POLYGON_SAT_OVERLAP_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CPSAT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CPSAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cpsat_pkg.sv]
// Constants, control word layout and microcode ROM for the polygon overlap block.
package cpsat_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 16;

    localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int AXIS_W = COORD_BITS + 1;
    localparam int PROD_W = COORD_BITS + AXIS_W;
    localparam int PROJ_W = PROD_W + 1;
    localparam int VERT_W = 2 * COORD_BITS;

    localparam logic signed [PROJ_W-1:0] PROJ_MAX = {1'b0, {(PROJ_W-1){1'b1}}};
    localparam logic signed [PROJ_W-1:0] PROJ_MIN = {1'b1, {(PROJ_W-1){1'b0}}};

    // Command codes
    localparam logic [1:0] FUNC_APPEND_A = 2'd0;
    localparam logic [1:0] FUNC_APPEND_B = 2'd1;
    localparam logic [1:0] FUNC_TEST     = 2'd2;
    localparam logic [1:0] FUNC_CLEAR    = 2'd3;

    // Sequencer steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_INIT   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_RD_I   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_RD_NXT = 4'd3;
    localparam logic [STEP_W-1:0] STEP_AXIS   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_PROJ_A = 4'd5;
    localparam logic [STEP_W-1:0] STEP_PROJ_B = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DRAIN0 = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DRAIN1 = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_REPORT = 4'd10;

    // Read address select
    localparam logic [1:0] ADDR_J   = 2'd0;
    localparam logic [1:0] ADDR_I   = 2'd1;
    localparam logic [1:0] ADDR_NXT = 2'd2;

    // Projection issue
    localparam logic [1:0] ISSUE_NONE = 2'd0;
    localparam logic [1:0] ISSUE_A    = 2'd1;
    localparam logic [1:0] ISSUE_B    = 2'd2;

    // Datapath actions
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_INIT   = 3'd1;
    localparam logic [2:0] ACT_LATCH  = 3'd2;
    localparam logic [2:0] ACT_AXIS   = 3'd3;
    localparam logic [2:0] ACT_JINC   = 3'd4;
    localparam logic [2:0] ACT_CHECK  = 3'd5;
    localparam logic [2:0] ACT_REPORT = 3'd6;

    // Jump conditions
    localparam logic [2:0] COND_NEVER      = 3'd0;
    localparam logic [2:0] COND_ALWAYS     = 3'd1;
    localparam logic [2:0] COND_NOT_TEST   = 3'd2;
    localparam logic [2:0] COND_A_EMPTY    = 3'd3;
    localparam logic [2:0] COND_J_MORE     = 3'd4;
    localparam logic [2:0] COND_MORE_EDGES = 3'd5;

    typedef struct packed {
        logic [1:0]        addr_sel;
        logic [1:0]        issue;
        logic [2:0]        act;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } t_cw;

    function automatic t_cw cpsat_rom(input logic [STEP_W-1:0] step);
        t_cw cw;
        cw = '{ADDR_J, ISSUE_NONE, ACT_NONE, COND_ALWAYS, STEP_IDLE};
        unique case (step)
            STEP_IDLE:   cw = '{ADDR_J,   ISSUE_NONE, ACT_NONE,   COND_NOT_TEST,   STEP_IDLE};
            STEP_INIT:   cw = '{ADDR_J,   ISSUE_NONE, ACT_INIT,   COND_A_EMPTY,    STEP_REPORT};
            STEP_RD_I:   cw = '{ADDR_I,   ISSUE_NONE, ACT_NONE,   COND_NEVER,      STEP_IDLE};
            STEP_RD_NXT: cw = '{ADDR_NXT, ISSUE_NONE, ACT_LATCH,  COND_NEVER,      STEP_IDLE};
            STEP_AXIS:   cw = '{ADDR_J,   ISSUE_NONE, ACT_AXIS,   COND_NEVER,      STEP_IDLE};
            STEP_PROJ_A: cw = '{ADDR_J,   ISSUE_A,    ACT_JINC,   COND_J_MORE,     STEP_PROJ_A};
            STEP_PROJ_B: cw = '{ADDR_J,   ISSUE_B,    ACT_JINC,   COND_J_MORE,     STEP_PROJ_B};
            STEP_DRAIN0: cw = '{ADDR_J,   ISSUE_NONE, ACT_NONE,   COND_NEVER,      STEP_IDLE};
            STEP_DRAIN1: cw = '{ADDR_J,   ISSUE_NONE, ACT_NONE,   COND_NEVER,      STEP_IDLE};
            STEP_CHECK:  cw = '{ADDR_J,   ISSUE_NONE, ACT_CHECK,  COND_MORE_EDGES, STEP_RD_I};
            STEP_REPORT: cw = '{ADDR_J,   ISSUE_NONE, ACT_REPORT, COND_ALWAYS,     STEP_IDLE};
            default:     cw = '{ADDR_J,   ISSUE_NONE, ACT_NONE,   COND_ALWAYS,     STEP_IDLE};
        endcase
        return cw;
    endfunction

endpackage

[hw/rtl/cpsat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cpsat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hw/rtl/convex_polygon_sat_overlap_top.sv]
// Top level of the 2-D convex polygon overlap tester (separating-axis test).
//
// Usage: drive i_func / i_vert_x / i_vert_y with start high while busy is low.
// Append and clear commands finish in the cycle they are taken; busy stays low,
// so appends stream one per cycle. A test command raises busy and runs a short
// microprogram: for each edge of polygon A it reads the two endpoints, forms the
// edge normal, then streams every vertex of A and of B through a two-stage
// project pipeline (registered multiply, then add plus running min/max) and
// checks the intervals for a strict gap. With A empty it goes straight to the
// result, and it ends early at the first separating edge; each store has a
// single read port, so the vertices are read one at a time. In the first
// cycle with busy low again, o_done pulses for one cycle with o_overlap and
// o_vertex_dropped; the receiver cannot stall it, so sample it on that edge.
// Appends beyond the store depth are discarded and flag o_vertex_dropped until
// the next clear.
module convex_polygon_sat_overlap_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic signed [cpsat_pkg::COORD_BITS-1:0] i_vert_x,
    input  logic signed [cpsat_pkg::COORD_BITS-1:0] i_vert_y,
    output logic       o_done,
    output logic       o_overlap,
    output logic       o_vertex_dropped
);

    import cpsat_pkg::*;

    // Sequencer
    logic [STEP_W-1:0] r_step, n_step;
    t_cw               cw;
    logic              accept;
    logic              jump;

    // Stores and counts
    logic [CNT_W-1:0] r_cnt_a, r_cnt_b;
    logic             r_dropped;
    logic             we_a, we_b;
    logic [IDX_W-1:0] raddr;
    logic [VERT_W-1:0] rdata_a, rdata_b, wdata;

    // Edge loop
    logic [IDX_W-1:0] r_i, r_j, nxt;
    logic [CNT_W-1:0] j_lim;
    logic             j_more;
    logic             r_overlap;

    // Axis
    logic signed [COORD_BITS-1:0] r_ei_x, r_ei_y;
    logic signed [COORD_BITS-1:0] rd_a_x, rd_a_y, rd_x, rd_y;
    logic signed [AXIS_W-1:0]     r_nx, r_ny;

    // Projection pipeline
    logic                     issue_vld;
    logic                     r_rd_vld, r_rd_side, r_mul_vld, r_mul_side;
    logic signed [PROD_W-1:0] r_px, r_py;
    logic signed [PROJ_W-1:0] proj;
    logic signed [PROJ_W-1:0] r_min_a, r_max_a, r_min_b, r_max_b;
    logic                     sep;

    assign cw     = cpsat_rom(r_step);
    assign busy   = (r_step != STEP_IDLE);
    assign accept = start && (r_step == STEP_IDLE);

    // Append writes happen while idle, one per transaction
    assign wdata = {i_vert_y, i_vert_x};
    assign we_a  = accept && (i_func == FUNC_APPEND_A) && (r_cnt_a != CNT_W'(MAX_VERTICES));
    assign we_b  = accept && (i_func == FUNC_APPEND_B) && (r_cnt_b != CNT_W'(MAX_VERTICES));

    // Next vertex index with wrap to zero
    assign nxt = ((CNT_W'(r_i) + 1'b1) < r_cnt_a) ? r_i + 1'b1 : '0;

    always_comb begin
        unique case (cw.addr_sel)
            ADDR_I:   raddr = r_i;
            ADDR_NXT: raddr = nxt;
            default:  raddr = r_j;
        endcase
    end

    cpsat_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_store_a (
        .i_clk  (i_clk),
        .i_we   (we_a),
        .i_waddr(r_cnt_a[IDX_W-1:0]),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_a)
    );

    cpsat_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_store_b (
        .i_clk  (i_clk),
        .i_we   (we_b),
        .i_waddr(r_cnt_b[IDX_W-1:0]),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_b)
    );

    assign rd_a_x = rdata_a[COORD_BITS-1:0];
    assign rd_a_y = rdata_a[VERT_W-1:COORD_BITS];
    assign rd_x   = r_rd_side ? rdata_b[COORD_BITS-1:0] : rd_a_x;
    assign rd_y   = r_rd_side ? rdata_b[VERT_W-1:COORD_BITS] : rd_a_y;

    // Inner loop bound follows the store being projected
    assign j_lim     = (cw.issue == ISSUE_B) ? r_cnt_b : r_cnt_a;
    assign j_more    = (CNT_W'(r_j) + 1'b1) < j_lim;
    assign issue_vld = (cw.issue != ISSUE_NONE) && (CNT_W'(r_j) < j_lim);

    assign proj = PROJ_W'(r_px) + PROJ_W'(r_py);
    assign sep  = (r_max_a < r_min_b) || (r_max_b < r_min_a);

    always_comb begin
        unique case (cw.cond)
            COND_NEVER:      jump = 1'b0;
            COND_ALWAYS:     jump = 1'b1;
            COND_NOT_TEST:   jump = !(accept && (i_func == FUNC_TEST));
            COND_A_EMPTY:    jump = (r_cnt_a == '0);
            COND_J_MORE:     jump = j_more;
            COND_MORE_EDGES: jump = !sep && ((CNT_W'(r_i) + 1'b1) < r_cnt_a);
            default:         jump = 1'b0;
        endcase
        n_step = jump ? cw.target : r_step + 1'b1;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= STEP_IDLE;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_dropped  <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_mul_vld  <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_rd_vld  <= issue_vld;
            r_mul_vld <= r_rd_vld;
            o_done    <= (cw.act == ACT_REPORT);
            if (accept) begin
                case (i_func)
                    FUNC_APPEND_A: begin
                        if (we_a) r_cnt_a <= r_cnt_a + 1'b1;
                        else      r_dropped <= 1'b1;
                    end
                    FUNC_APPEND_B: begin
                        if (we_b) r_cnt_b <= r_cnt_b + 1'b1;
                        else      r_dropped <= 1'b1;
                    end
                    FUNC_CLEAR: begin
                        r_cnt_a   <= '0;
                        r_cnt_b   <= '0;
                        r_dropped <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_rd_side  <= (cw.issue == ISSUE_B);
        r_mul_side <= r_rd_side;
        r_px       <= rd_x * r_nx;
        r_py       <= rd_y * r_ny;

        case (cw.act)
            ACT_INIT: begin
                r_i       <= '0;
                r_overlap <= 1'b1;
            end
            ACT_LATCH: begin
                r_ei_x <= rd_a_x;
                r_ei_y <= rd_a_y;
            end
            ACT_AXIS: begin
                // normal of edge (i -> nxt): (-(yi - yn), xi - xn)
                r_nx    <= AXIS_W'(rd_a_y) - AXIS_W'(r_ei_y);
                r_ny    <= AXIS_W'(r_ei_x) - AXIS_W'(rd_a_x);
                r_j     <= '0;
                r_min_a <= PROJ_MAX;
                r_max_a <= PROJ_MIN;
                r_min_b <= PROJ_MAX;
                r_max_b <= PROJ_MIN;
            end
            ACT_JINC: begin
                r_j <= j_more ? r_j + 1'b1 : '0;
            end
            ACT_CHECK: begin
                if (sep) r_overlap <= 1'b0;
                r_i <= r_i + 1'b1;
            end
            ACT_REPORT: begin
                o_overlap        <= r_overlap;
                o_vertex_dropped <= r_dropped;
            end
            default: ;
        endcase

        if (r_mul_vld) begin
            if (r_mul_side) begin
                if (proj < r_min_b) r_min_b <= proj;
                if (proj > r_max_b) r_max_b <= proj;
            end else begin
                if (proj < r_min_a) r_min_a <= proj;
                if (proj > r_max_a) r_max_a <= proj;
            end
        end
    end

    `include "convex_polygon_sat_overlap_top_assert.svh"

    `CPSAT_ASSERT_IMPL(a_done_when_idle, o_done, !busy, "result strobe while busy")
    `CPSAT_ASSERT_NEXT(a_test_goes_busy, accept && (i_func == FUNC_TEST), busy, "test not started")
    `CPSAT_ASSERT_IMPL(a_cnt_bound, 1'b1, (r_cnt_a <= CNT_W'(MAX_VERTICES)) && (r_cnt_b <= CNT_W'(MAX_VERTICES)), "vertex count over capacity")
    `CPSAT_ASSERT_IMPL(a_pipe_empty_at_check, r_step == STEP_CHECK, !r_rd_vld && !r_mul_vld, "projection pipeline not drained at check")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the convex polygon separating-axis overlap block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cpsat_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. All inputs start at known values.
    // ------------------------------------------------------------------
    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [1:0]                   i_func = FUNC_CLEAR;
    logic signed [COORD_BITS-1:0] i_vert_x = '0;
    logic signed [COORD_BITS-1:0] i_vert_y = '0;
    logic                         o_done;
    logic                         o_overlap;
    logic                         o_vertex_dropped;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    convex_polygon_sat_overlap_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_vert_x        (i_vert_x),
        .i_vert_y        (i_vert_y),
        .o_done          (o_done),
        .o_overlap       (o_overlap),
        .o_vertex_dropped(o_vertex_dropped)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the polygon stores. Only entries below the counts are
    // ever read, so stale entries left behind by a clear never matter.
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] poly_a_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] poly_a_y [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] poly_b_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] poly_b_y [MAX_VERTICES];
    int unsigned                  n_a = 0;
    int unsigned                  n_b = 0;
    logic                         drop_flag = 1'b0;

    // One entry per accepted test transaction, oldest first.
    typedef struct packed {
        logic overlap;
        logic dropped;
    } t_verdict;

    t_verdict    pending_verdicts [$];
    t_verdict    oldest_verdict;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    bit          gaps_on = 1'b1;

    // Exact-integer separating-axis test over A's edge normals. The axis is
    // the unnormalized perpendicular of each edge; a zero-length edge gives
    // all-zero projections and so can never separate. Empty B leaves its
    // interval inverted, which makes every axis separate.
    function automatic logic sat_overlap();
        int unsigned nxt;
        longint      ax, ay, proj;
        longint      lo_a, hi_a, lo_b, hi_b;
        for (int unsigned i = 0; i < n_a; i++) begin
            nxt  = (i + 1 < n_a) ? i + 1 : 0;
            ax   = -(longint'(poly_a_y[i]) - longint'(poly_a_y[nxt]));
            ay   = longint'(poly_a_x[i]) - longint'(poly_a_x[nxt]);
            lo_a = 64'sh7fff_ffff_ffff_ffff;
            hi_a = 64'sh8000_0000_0000_0000;
            lo_b = lo_a;
            hi_b = hi_a;
            for (int unsigned j = 0; j < n_a; j++) begin
                proj = longint'(poly_a_x[j]) * ax + longint'(poly_a_y[j]) * ay;
                if (proj < lo_a) lo_a = proj;
                if (proj > hi_a) hi_a = proj;
            end
            for (int unsigned j = 0; j < n_b; j++) begin
                proj = longint'(poly_b_x[j]) * ax + longint'(poly_b_y[j]) * ay;
                if (proj < lo_b) lo_b = proj;
                if (proj > hi_b) hi_b = proj;
            end
            // strict gap only; touching ends still overlap
            if (hi_a < lo_b || hi_b < lo_a) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("[%0t] mismatch: %s (got %b, want %b)", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Sender: one transaction per call. Inputs move on the falling edge,
    // acceptance is judged on the rising edge (start high, busy low).
    // The shadow state is updated the moment the transaction is taken.
    // Coordinates keep their low COORD_BITS bits.
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [1:0] func,
                            input int x,
                            input int y);
        t_verdict v;
        // random idle gap before roughly a third of the transactions
        if (gaps_on && $urandom_range(99) < 35) begin
            @(negedge i_clk);
            start    <= 1'b0;
            i_func   <= 2'($urandom);
            i_vert_x <= COORD_BITS'($urandom);
            i_vert_y <= COORD_BITS'($urandom);
            repeat ($urandom_range(1)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start    <= 1'b1;
        i_func   <= func;
        i_vert_x <= COORD_BITS'(x);
        i_vert_y <= COORD_BITS'(y);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        case (func)
            FUNC_APPEND_A: begin
                if (n_a >= MAX_VERTICES) begin
                    drop_flag = 1'b1;
                end else begin
                    poly_a_x[n_a] = COORD_BITS'(x);
                    poly_a_y[n_a] = COORD_BITS'(y);
                    n_a++;
                end
            end
            FUNC_APPEND_B: begin
                if (n_b >= MAX_VERTICES) begin
                    drop_flag = 1'b1;
                end else begin
                    poly_b_x[n_b] = COORD_BITS'(x);
                    poly_b_y[n_b] = COORD_BITS'(y);
                    n_b++;
                end
            end
            FUNC_CLEAR: begin
                n_a       = 0;
                n_b       = 0;
                drop_flag = 1'b0;
            end
            FUNC_TEST: begin
                v.overlap = sat_overlap();
                v.dropped = drop_flag;
                pending_verdicts.push_back(v);
            end
        endcase
    endtask

    // Drop start, then hold off until every queued test result is back.
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Axis-aligned square, corners counter-clockwise from (x0, y0).
    task automatic append_box(input logic [1:0] func, input int x0, input int y0,
                              input int w);
        send_cmd(func, x0,     y0);
        send_cmd(func, x0 + w, y0);
        send_cmd(func, x0 + w, y0 + w);
        send_cmd(func, x0,     y0 + w);
    endtask

    // Convex shape: a subset of the corners of an octagon, scaled per axis
    // and shifted. Any subset of a convex polygon's corners stays convex.
    task automatic append_shape(input logic [1:0] func, input int cx, input int cy,
                                input int rx, input int ry, input logic [7:0] mask,
                                input bit reverse);
        int k, dx, dy;
        for (int n = 0; n < 8; n++) begin
            k = reverse ? 7 - n : n;
            case (k)
                0: begin dx =  3; dy =  0; end
                1: begin dx =  2; dy =  2; end
                2: begin dx =  0; dy =  3; end
                3: begin dx = -2; dy =  2; end
                4: begin dx = -3; dy =  0; end
                5: begin dx = -2; dy = -2; end
                6: begin dx =  0; dy = -3; end
                default: begin dx = 2; dy = -2; end
            endcase
            if (mask[k]) send_cmd(func, cx + rx * dx, cy + ry * dy);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: o_done is a one-cycle strobe that cannot be stalled,
    // so it is sampled on the rising edge that ends its cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with no test pending", o_done, 1'b0);
            end else begin
                oldest_verdict = pending_verdicts.pop_front();
                if (o_overlap !== oldest_verdict.overlap)
                    report_mismatch("overlap", o_overlap, oldest_verdict.overlap);
                if (o_vertex_dropped !== oldest_verdict.dropped)
                    report_mismatch("vertex_dropped", o_vertex_dropped,
                                    oldest_verdict.dropped);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Empty A always overlaps; non-empty A against empty B never does.
    task automatic test_empty_polygons();
        send_cmd(FUNC_TEST, $urandom, $urandom);
        send_cmd(FUNC_APPEND_B, 5, 5);
        send_cmd(FUNC_TEST, 0, 0);
        send_cmd(FUNC_CLEAR, $urandom, $urandom);
        send_cmd(FUNC_APPEND_A, 0, 0);
        send_cmd(FUNC_TEST, 0, 0);
    endtask

    // Single vertex and repeated vertices give zero-length edges / axes.
    task automatic test_degenerate_edges();
        send_cmd(FUNC_APPEND_B, 100, -100);
        send_cmd(FUNC_TEST, 0, 0);
        send_cmd(FUNC_APPEND_A, 0, 0);
        send_cmd(FUNC_APPEND_A, 40, 0);
        send_cmd(FUNC_TEST, 0, 0);
    endtask

    // Shared edge counts as overlap, a one-unit gap separates.
    task automatic test_touching_and_gap();
        send_cmd(FUNC_CLEAR, 0, 0);
        append_box(FUNC_APPEND_A, 0, 0, 10);
        append_box(FUNC_APPEND_B, 10, 0, 10);
        send_cmd(FUNC_TEST, 0, 0);
        send_cmd(FUNC_CLEAR, 0, 0);
        append_box(FUNC_APPEND_A, 0, 0, 10);
        append_box(FUNC_APPEND_B, 11, 3, 10);
        send_cmd(FUNC_TEST, 0, 0);
    endtask

    // Full-scale coordinates exercise the widest edge and product terms.
    task automatic test_extreme_coords();
        send_cmd(FUNC_CLEAR, -1, -1);
        send_cmd(FUNC_APPEND_A, -32768, -32768);
        send_cmd(FUNC_APPEND_A,  32767, -32768);
        send_cmd(FUNC_APPEND_A,  32767,  32767);
        send_cmd(FUNC_APPEND_B, -32768,  32767);
        send_cmd(FUNC_TEST, 0, 0);
        send_cmd(FUNC_APPEND_B, -32767,  32767);
        send_cmd(FUNC_APPEND_B, -32768, -32767);
        send_cmd(FUNC_TEST, -32768, 32767);
    endtask

    // Both stores filled past depth: largest test, flag set, flag cleared.
    task automatic test_store_capacity();
        send_cmd(FUNC_CLEAR, 0, 0);
        repeat (MAX_VERTICES + 1) send_cmd(FUNC_APPEND_A, $urandom, $urandom);
        send_cmd(FUNC_TEST, 0, 0);
        repeat (MAX_VERTICES + 2) send_cmd(FUNC_APPEND_B, $urandom, $urandom);
        send_cmd(FUNC_TEST, 0, 0);
        send_cmd(FUNC_CLEAR, 0, 0);
        send_cmd(FUNC_TEST, 0, 0);
        drain_results();   // sender holds off until every result is back
    endtask

    // ------------------------------------------------------------------
    // Random part: mostly clear / A shape / B shape / test sequences with
    // random placement and size, plus raw noise and broken sequences
    // (no clear, overfill, test mid-build).
    // ------------------------------------------------------------------
    task automatic test_random_sequences(input int unsigned target);
        int unsigned stop_at, base, seq, pick;
        int cx, cy, bx, by, rax, ray, rbx, rby, spanx, spany;
        base    = items_sent;
        stop_at = items_sent + target;
        seq     = 0;
        while (items_sent < stop_at) begin
            // one long stretch with no idle gaps at all
            gaps_on = !((items_sent - base) >= 400 && (items_sent - base) < 700);
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(9) != 0) send_cmd(FUNC_CLEAR, $urandom, $urandom);
                cx    = int'($urandom_range(24000)) - 12000;
                cy    = int'($urandom_range(24000)) - 12000;
                rax   = $urandom_range(1, 1500);
                ray   = $urandom_range(1, 1500);
                rbx   = $urandom_range(1, 1500);
                rby   = $urandom_range(1, 1500);
                spanx = 3 * (rax + rbx);
                spany = 3 * (ray + rby);
                bx    = cx + int'($urandom_range(2 * spanx)) - spanx;
                by    = cy + int'($urandom_range(2 * spany)) - spany;
                append_shape(FUNC_APPEND_A, cx, cy, rax, ray, 8'($urandom_range(1, 255)),
                             1'($urandom_range(1)));
                append_shape(FUNC_APPEND_B, bx, by, rbx, rby, 8'($urandom_range(1, 255)),
                             1'($urandom_range(1)));
                send_cmd(FUNC_TEST, $urandom, $urandom);
                if ($urandom_range(7) == 0) send_cmd(FUNC_TEST, $urandom, $urandom);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 8)) send_cmd(2'($urandom), $urandom, $urandom);
            end else begin
                repeat ($urandom_range(1, 20))
                    send_cmd($urandom_range(1) ? FUNC_APPEND_A : FUNC_APPEND_B,
                             $urandom, $urandom);
                send_cmd(FUNC_TEST, $urandom, $urandom);
            end
            seq++;
            if (seq % 40 == 20) drain_results();
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset once, directed tests, random tests, then drain
    // and a short quiet window to catch any stray result strobe.
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_polygons();
        test_degenerate_edges();
        test_touching_and_gap();
        test_extreme_coords();
        test_store_capacity();
        test_random_sequences(1300);

        drain_results();
        if (pending_verdicts.size() != 0)
            report_mismatch("test results never arrived", 1'b0, 1'b1);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the longest legal run (every test at full depth).
    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
